[rtl/cbf_pkg.sv]
// ============================================================================
// cbf_pkg
// Shared widths, register indexes, controller states and the command and
// status bundles of the cubic Bezier flattener.
// ============================================================================
package cbf_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_STEPS  = 64;
    localparam int STEP_W     = 7;
    localparam int PIX_W      = 13;
    localparam int COLOR_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int OFF_W      = 12;
    localparam int PT_W       = 34;   // scaled point, Q.12
    localparam int W_W        = 19;   // Bernstein weight, up to n^3
    localparam int ACC_W      = 56;   // weighted sum
    localparam int MAG_W      = 52;   // magnitude of the weighted sum
    localparam int DSH_W      = 42;   // n^3 * 4096 shifted by the top quotient bit
    localparam int Q_W        = 12;   // unsaturated quotient magnitude bits
    localparam int ADDR_W     = 5;
    localparam int IN_W       = 8 * COORD_BITS;
    localparam int OUT_W      = 72;

    localparam logic [2:0] REG_SCALE  = 3'd0;
    localparam logic [2:0] REG_OFFX   = 3'd1;
    localparam logic [2:0] REG_OFFY   = 3'd2;
    localparam logic [2:0] REG_STEPS  = 3'd3;
    localparam logic [2:0] REG_COLOR  = 3'd4;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 13'sd4095;
    localparam logic signed [PIX_W-1:0] PIX_MIN = -13'sd4096;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WGT1,
        ST_WGT2,
        ST_MAC,
        ST_DCHK,
        ST_DIV,
        ST_RES,
        ST_OUT
    } cbf_state_t;

    typedef struct packed {
        logic       load_in;
        logic       scale_en;
        logic [2:0] idx;
        logic       wgt1;
        logic       wgt2;
        logic       mac_clr;
        logic       mac_en;
        logic       axis;
        logic       div_init;
        logic       div_step;
        logic       store;
        logic       set_prev;
        logic       emit;
        logic       last;
    } cbf_cmd_t;

    typedef struct packed {
        logic out_free;
    } cbf_status_t;

    // Clamp the step count into 1..MAX_STEPS.
    function automatic logic [STEP_W-1:0] eff_steps(input logic [STEP_W-1:0] n);
        logic [STEP_W-1:0] r;
        begin
            r = n;
            if (n == '0)
            begin
                r = STEP_W'(1);
            end
            else if (n > STEP_W'(MAX_STEPS))
            begin
                r = STEP_W'(MAX_STEPS);
            end
            return r;
        end
    endfunction

endpackage

[rtl/cbf_ctrl.sv]
// ============================================================================
// cbf_ctrl
// Sequencer: scales the control points, then per step builds weights,
// accumulates each axis and divides it, and hands segments to the output.
// ============================================================================
module cbf_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [cbf_pkg::STEP_W-1:0]  n,
    output logic [cbf_pkg::STEP_W-1:0]  s,
    input  cbf_pkg::cbf_status_t        status,
    output cbf_pkg::cbf_cmd_t           cmd
);
    import cbf_pkg::*;

    cbf_state_t        state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [3:0]        bit_reg, bit_next;
    logic [STEP_W-1:0] s_reg, s_next;
    logic              axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bit_reg   <= '0;
            s_reg     <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
            s_reg     <= s_next;
            axis_reg  <= axis_next;
        end
    end

    assign s = s_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        s_next     = s_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        cmd.axis   = axis_reg;
        cmd.last   = (s_reg == n);
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    s_next     = '0;
                    axis_next  = 1'b0;
                    state_next = ST_WGT1;
                end
            end
            ST_WGT1:
            begin
                cmd.wgt1   = 1'b1;
                state_next = ST_WGT2;
            end
            ST_WGT2:
            begin
                cmd.wgt2    = 1'b1;
                cmd.mac_clr = 1'b1;
                cnt_next    = '0;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK:
            begin
                cmd.div_init = 1'b1;
                bit_next     = 4'd11;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                cmd.store = 1'b1;
                if (!axis_reg)
                begin
                    axis_next   = 1'b1;
                    cmd.mac_clr = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_MAC;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (s_reg == '0)
                begin
                    cmd.set_prev = 1'b1;
                    s_next       = s_reg + STEP_W'(1);
                    axis_next    = 1'b0;
                    state_next   = ST_WGT1;
                end
                else if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    axis_next = 1'b0;
                    if (s_reg == n)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + STEP_W'(1);
                        state_next = ST_WGT1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/cbf_datapath.sv]
// ============================================================================
// cbf_datapath
// Point scaling, Bernstein weights, shared multiply-accumulate, restoring
// divider with saturation, and the output register.
// ============================================================================
module cbf_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cbf_pkg::cbf_cmd_t                  cmd,
    output cbf_pkg::cbf_status_t               status,
    input  logic [cbf_pkg::IN_W-1:0]           in_data,
    input  logic [cbf_pkg::SCALE_W-1:0]        scale,
    input  logic [cbf_pkg::OFF_W-1:0]          off_x,
    input  logic [cbf_pkg::OFF_W-1:0]          off_y,
    input  logic [cbf_pkg::COLOR_W-1:0]        color,
    input  logic [cbf_pkg::STEP_W-1:0]         n,
    input  logic [cbf_pkg::STEP_W-1:0]         s,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cbf_pkg::OUT_W-1:0]          out_data,
    output logic                               out_last
);
    import cbf_pkg::*;

    logic [COORD_BITS-1:0]  raw_reg [8];
    logic signed [PT_W-1:0] pts_reg [8];
    logic [13:0]            uu_reg, ss_reg, nn_reg;
    logic [W_W-1:0]         w_reg [4];
    logic [W_W-1:0]         n3_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [MAG_W-1:0]       rem_reg;
    logic [DSH_W-1:0]       dsh_reg;
    logic [Q_W-1:0]         q_reg;
    logic                   neg_reg, sat_reg;
    logic signed [PIX_W-1:0] newx_reg, newy_reg, prevx_reg, prevy_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_last_reg;
    logic                   out_valid_reg;

    // Scale one coordinate
    logic [OFF_W-1:0]        off_sel;
    logic signed [32:0]      sprod;
    logic signed [PT_W-1:0]  scaled;
    assign off_sel = cmd.idx[0] ? off_y : off_x;
    assign sprod   = $signed(raw_reg[cmd.idx]) * $signed({1'b0, scale});
    assign scaled  = $signed({sprod[32], sprod})
                   + $signed({{(PT_W-OFF_W-12){off_sel[OFF_W-1]}}, off_sel, 12'b0});

    // Weights
    logic [STEP_W-1:0] u;
    logic [20:0]       uus, ssu, t0, t3, n3;
    assign u   = n - s;
    assign uus = uu_reg * s;
    assign ssu = ss_reg * u;
    assign t0  = uu_reg * u;
    assign t3  = ss_reg * s;
    assign n3  = nn_reg * n;

    // Multiply-accumulate
    logic [2:0]              pidx;
    logic signed [PT_W-1:0]  psel;
    logic [W_W-1:0]          wsel;
    logic [35:0]             plo;
    logic signed [36:0]      phi;
    logic signed [ACC_W-1:0] prod;
    assign pidx = {cmd.idx[2:1], cmd.axis};
    assign psel = pts_reg[pidx];
    assign wsel = w_reg[cmd.idx[2:1]];
    assign plo  = wsel * psel[16:0];
    assign phi  = $signed({1'b0, wsel}) * $signed(psel[PT_W-1:17]);
    assign prod = cmd.idx[0] ? $signed({{(ACC_W-37-17){phi[36]}}, phi, 17'b0})
                             : $signed({{(ACC_W-36){1'b0}}, plo});

    // Division
    logic [ACC_W-1:0]  acc_abs;
    logic [MAG_W-1:0]  rem_cmp;
    logic              ge;
    logic [PIX_W-1:0]  qx;
    logic signed [PIX_W-1:0] res;
    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign rem_cmp = {{(MAG_W-DSH_W){1'b0}}, dsh_reg};
    assign ge      = (rem_reg >= rem_cmp);
    assign qx      = {1'b0, q_reg};

    always_comb
    begin
        if (sat_reg)
        begin
            res = neg_reg ? PIX_MIN : PIX_MAX;
        end
        else
        begin
            res = neg_reg ? $signed(-qx) : $signed(qx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int i = 0; i < 8; i++)
            begin
                raw_reg[i] <= in_data[i*COORD_BITS +: COORD_BITS];
            end
        end
        if (cmd.scale_en)
        begin
            pts_reg[cmd.idx] <= scaled;
        end
        if (cmd.wgt1)
        begin
            uu_reg <= u * u;
            ss_reg <= s * s;
            nn_reg <= n * n;
        end
        if (cmd.wgt2)
        begin
            w_reg[0] <= t0[W_W-1:0];
            w_reg[1] <= W_W'((uus << 1) + uus);
            w_reg[2] <= W_W'((ssu << 1) + ssu);
            w_reg[3] <= t3[W_W-1:0];
            n3_reg   <= n3[W_W-1:0];
        end
        if (cmd.mac_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_reg <= acc_reg + prod;
        end
        if (cmd.div_init)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            sat_reg <= (acc_abs[MAG_W-1:0] >= {{(MAG_W-W_W-24){1'b0}}, n3_reg, 24'b0});
            rem_reg <= acc_abs[MAG_W-1:0];
            dsh_reg <= {n3_reg, 23'b0};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - rem_cmp;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
        if (cmd.store)
        begin
            if (cmd.axis)
            begin
                newy_reg <= res;
            end
            else
            begin
                newx_reg <= res;
            end
        end
        if (cmd.set_prev || cmd.emit)
        begin
            prevx_reg <= newx_reg;
            prevy_reg <= newy_reg;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {4'b0, color, newy_reg, newx_reg, prevy_reg, prevx_reg};
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/cubic_bezier_flattener.sv]
// ============================================================================
// cubic_bezier_flattener
// Splits one cubic Bezier curve into straight line segments in pixels.
// ============================================================================
// One transfer on the slave side carries four Q12.4 control points. Every
// coordinate is scaled by the Q8.8 scale register and shifted by the pixel
// offset, then the curve is evaluated exactly at t = s/n for s = 0..n, where
// n is the step count clamped to 1..64. Each point is the Bernstein sum
// divided by n^3*4096, truncated toward zero and saturated to 13 bits. For
// every s from 1 on, one transfer on the master side carries the segment
// from the previous point to the new one, with the line color; tlast marks
// the final segment. The control points are first scaled one coordinate at
// a time; then for each of the n+1 evaluation points the weights are built
// in two steps and, per axis, the terms are multiply-accumulated (one
// shared 20x17 multiplier, two halves per term), divided bit-serially and
// stored, and the output step waits until the output register is free.
// A new curve is accepted once the last segment sits in the output
// register. The user must write registers over the APB port only while
// the block is idle; the block itself does not enforce this.
// ============================================================================
module cubic_bezier_flattener
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Curve input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    // (16 bits each, from bit 0 up)
    input  logic [cbf_pkg::IN_W-1:0]      s_axis_tdata,
    // Segment output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // from_x[12:0], from_y[25:13], to_x[38:26], to_y[51:39],
    // seg_color[67:52], zero fill [71:68]
    output logic [cbf_pkg::OUT_W-1:0]     m_axis_tdata,
    // last_segment
    output logic                          m_axis_tlast
);
    import cbf_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic [OFF_W-1:0]   offx_reg;
    logic [OFF_W-1:0]   offy_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [COLOR_W-1:0] color_reg;

    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Register file: write on the APB access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(256);
            offx_reg  <= '0;
            offy_reg  <= '0;
            steps_reg <= STEP_W'(8);
            color_reg <= '1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SCALE: scale_reg <= pwdata[SCALE_W-1:0];
                REG_OFFX:  offx_reg  <= pwdata[OFF_W-1:0];
                REG_OFFY:  offy_reg  <= pwdata[OFF_W-1:0];
                REG_STEPS: steps_reg <= pwdata[STEP_W-1:0];
                REG_COLOR: color_reg <= pwdata[COLOR_W-1:0];
                default:   ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_SCALE: prdata = {16'b0, scale_reg};
            REG_OFFX:  prdata = {20'b0, offx_reg};
            REG_OFFY:  prdata = {20'b0, offy_reg};
            REG_STEPS: prdata = {25'b0, steps_reg};
            REG_COLOR: prdata = {16'b0, color_reg};
            default:   prdata = '0;
        endcase
    end

    logic [STEP_W-1:0] n_eff;
    logic [STEP_W-1:0] s_cur;
    cbf_cmd_t          cmd;
    cbf_status_t       status;

    assign n_eff = eff_steps(steps_reg);

    cbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .n        (n_eff),
        .s        (s_cur),
        .status   (status),
        .cmd      (cmd)
    );

    cbf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .scale     (scale_reg),
        .off_x     (offx_reg),
        .off_y     (offy_reg),
        .color     (color_reg),
        .n         (n_eff),
        .s         (s_cur),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

[bench/cbf_checker.sv]
// ============================================================================
// cbf_checker
// Watches the APB port and both streams of the Bezier flattener, predicts
// each line segment of every accepted curve and compares it in order.
// ============================================================================
module cbf_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [cbf_pkg::IN_W-1:0]      s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [cbf_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          m_axis_tlast,
    output int                            fail_count,
    output int                            pending,
    output int                            curves_seen,
    output int                            segments_seen
);
    import cbf_pkg::*;

    typedef struct packed {
        logic signed [PIX_W-1:0] from_x;
        logic signed [PIX_W-1:0] from_y;
        logic signed [PIX_W-1:0] to_x;
        logic signed [PIX_W-1:0] to_y;
        logic [COLOR_W-1:0]      color;
        logic                    last;
    } segment_t;

    segment_t            seg_q[$];
    logic [SCALE_W-1:0]  scale_r;
    logic [OFF_W-1:0]    offx_r;
    logic [OFF_W-1:0]    offy_r;
    logic [STEP_W-1:0]   steps_r;
    logic [COLOR_W-1:0]  color_r;

    assign pending = seg_q.size();

    function automatic logic signed [PIX_W-1:0] clamp_px(input longint v);
        if (v < -4096)
        begin
            return PIX_MIN;
        end
        if (v > 4095)
        begin
            return PIX_MAX;
        end
        return PIX_W'(v);
    endfunction

    // Q.12 point: raw * scale + offset pixels.
    function automatic longint scale_coord(input logic [15:0] raw, input logic [OFF_W-1:0] off);
        longint p;
        longint o;
        p = longint'($signed(raw));
        o = longint'($signed(off));
        return p * longint'(scale_r) + o * 4096;
    endfunction

    task automatic flatten_curve(input logic [IN_W-1:0] d);
        longint cx[4];
        longint cy[4];
        longint n;
        longint u;
        longint w[4];
        longint sx;
        longint sy;
        longint den;
        segment_t seg;
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        for (int i = 0; i < 4; i++)
        begin
            cx[i] = scale_coord(d[32*i +: 16], offx_r);
            cy[i] = scale_coord(d[32*i+16 +: 16], offy_r);
        end
        n = longint'(steps_r);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_STEPS)
        begin
            n = MAX_STEPS;
        end
        den = n * n * n * 4096;
        // division truncates toward zero, as the block does
        px = clamp_px(cx[0] / 4096);
        py = clamp_px(cy[0] / 4096);
        for (longint s = 1; s <= n; s++)
        begin
            u = n - s;
            w[0] = u * u * u;
            w[1] = 3 * u * u * s;
            w[2] = 3 * u * s * s;
            w[3] = s * s * s;
            sx = 0;
            sy = 0;
            for (int i = 0; i < 4; i++)
            begin
                sx += w[i] * cx[i];
                sy += w[i] * cy[i];
            end
            seg.from_x = px;
            seg.from_y = py;
            seg.to_x   = clamp_px(sx / den);
            seg.to_y   = clamp_px(sy / den);
            seg.color  = color_r;
            seg.last   = (s == n);
            seg_q.push_back(seg);
            px = seg.to_x;
            py = seg.to_y;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on segment %0d: %s got %0d expected %0d",
                 segments_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        logic signed [PIX_W-1:0] gx0;
        logic signed [PIX_W-1:0] gy0;
        logic signed [PIX_W-1:0] gx1;
        logic signed [PIX_W-1:0] gy1;
        if (!rst_n)
        begin
            scale_r       = 16'd256;
            offx_r        = '0;
            offy_r        = '0;
            steps_r       = 7'd8;
            color_r       = 16'hFFFF;
            seg_q.delete();
            fail_count    = 0;
            curves_seen   = 0;
            segments_seen = 0;
        end
        else
        begin
            // the output side first: a curve taken this edge cannot yield a segment here
            if (m_axis_tvalid && m_axis_tready)
            begin
                gx0 = m_axis_tdata[12:0];
                gy0 = m_axis_tdata[25:13];
                gx1 = m_axis_tdata[38:26];
                gy1 = m_axis_tdata[51:39];
                if (seg_q.size() == 0)
                begin
                    $display("unexpected segment %0d with nothing predicted", segments_seen);
                    fail_count++;
                end
                else
                begin
                    want = seg_q.pop_front();
                    if (gx0 != want.from_x) report_mismatch("from_x", gx0, want.from_x);
                    if (gy0 != want.from_y) report_mismatch("from_y", gy0, want.from_y);
                    if (gx1 != want.to_x) report_mismatch("to_x", gx1, want.to_x);
                    if (gy1 != want.to_y) report_mismatch("to_y", gy1, want.to_y);
                    if (m_axis_tdata[67:52] != want.color)
                        report_mismatch("seg_color", m_axis_tdata[67:52], want.color);
                    if (m_axis_tlast != want.last)
                        report_mismatch("last_segment", m_axis_tlast, want.last);
                end
                segments_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                flatten_curve(s_axis_tdata);
                curves_seen++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SCALE: scale_r = pwdata[SCALE_W-1:0];
                    REG_OFFX:  offx_r  = pwdata[OFF_W-1:0];
                    REG_OFFY:  offy_r  = pwdata[OFF_W-1:0];
                    REG_STEPS: steps_r = pwdata[STEP_W-1:0];
                    REG_COLOR: color_r = pwdata[COLOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[bench/tb.sv]
// ============================================================================
// tb
// Stimulus and verdict for the cubic Bezier flattener.
// ============================================================================
// Drives curves through the input stream under a series of register
// settings (defaults, both scale extremes, offset extremes, step counts of
// zero, one, 64 and above 64, an unmapped register), first a directed set
// and then random curves. Both stream sides idle at random, one phase runs
// with no idling at all, and one long receiver hold-off fills the block.
// The checker beside the block predicts and compares every segment.
// ============================================================================
module tb;
    import cbf_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    // register index past the end of the map, must be ignored
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;

    int  fail_count;
    int  pending;
    int  curves_seen;
    int  segments_seen;
    int  cycle_count;
    bit  idle_on;       // random idling on both sides
    bit  hold_req;      // ask the receiver for one long hold-off
    int  hold_left;

    cubic_bezier_flattener dut
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    cbf_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_count), .pending(pending),
        .curves_seen(curves_seen), .segments_seen(segments_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d segments outstanding", cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = 600;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready = 1'b0;
        end
        else
        begin
            m_axis_tready = !(idle_on && $urandom_range(0, 99) < 34);
        end
    end

    // APB write with a setup and an access phase; the register updates at the access-cycle edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_regs(input logic [15:0] scale, input logic [11:0] ox,
                                input logic [11:0] oy, input logic [6:0] steps,
                                input logic [15:0] color);
        write_reg(REG_SCALE, {16'h0, scale});
        write_reg(REG_OFFX, {20'h0, ox});
        write_reg(REG_OFFY, {20'h0, oy});
        write_reg(REG_STEPS, {25'h0, steps});
        write_reg(REG_COLOR, {16'h0, color});
    endtask

    // Offer one curve; hold tvalid until the transfer, then return at a falling edge.
    task automatic send_curve(input logic [IN_W-1:0] pts);
        while (idle_on && $urandom_range(0, 99) < 34)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pts;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Drop valid, drain every predicted segment, then let the block settle.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (60) @(negedge clk);
    endtask

    // Mostly on-screen coordinates, some full range, some at the extremes.
    function automatic logic [15:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            return 16'($signed($urandom_range(0, 8000)) - 4000);
        end
        if (pick < 90)
        begin
            return 16'($urandom);
        end
        return (pick < 95) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic logic [IN_W-1:0] rand_curve();
        logic [IN_W-1:0] c;
        for (int i = 0; i < 8; i++)
        begin
            c[16*i +: 16] = rand_coord();
        end
        return c;
    endfunction

    function automatic logic [IN_W-1:0] same_coords(input logic [15:0] v);
        return {8{v}};
    endfunction

    initial
    begin
        int steps;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed curves at the reset settings.
        send_curve('0);
        send_curve(same_coords(16'h7FFF));
        send_curve(same_coords(16'h8000));
        send_curve({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                    16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
        send_curve({16'd1600, 16'd1600, 16'd1100, 16'd1100,
                    16'd500, 16'd500, 16'd16, 16'd16});
        send_curve({16'hFFF0, 16'd0, 16'hFFFF, 16'd1, 16'd15, 16'hFFF1, 16'd17, 16'hFFEF});
        send_curve(same_coords(16'hAAAA));
        send_curve(same_coords(16'h5555));
        wait_drained();

        // Zero scale with offset extremes, single step.
        program_regs(16'h0000, 12'h800, 12'h7FF, 7'd1, 16'h0000);
        send_curve(rand_curve());
        send_curve(same_coords(16'h7FFF));
        wait_drained();

        // Largest scale, opposite offsets, 64 steps: saturates heavily.
        program_regs(16'hFFFF, 12'h7FF, 12'h800, 7'd64, 16'hF81F);
        send_curve(rand_curve());
        send_curve({16'd4, 16'hFFFC, 16'd2, 16'hFFFE, 16'hFFFE, 16'd2, 16'hFFFC, 16'd4});
        wait_drained();

        // Step count zero acts as one; the unmapped register changes nothing.
        program_regs(16'd512, 12'd100, 12'hF9C, 7'd0, 16'h07E0);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_curve(rand_curve());
        send_curve(rand_curve());
        wait_drained();

        // Step count above the maximum clamps to 64.
        program_regs(16'd256, 12'd0, 12'd0, 7'd127, 16'h001F);
        send_curve(rand_curve());
        wait_drained();

        // Random phases; phase 2 runs without idling, phase 4 has the long hold-off.
        for (int phase = 0; phase < 7; phase++)
        begin
            steps = (phase == 4) ? 16 : $urandom_range(1, 16);
            program_regs(16'($urandom_range(32, 1024)), 12'($urandom), 12'($urandom),
                         7'(steps), 16'($urandom));
            idle_on = (phase != 2);
            if (phase == 4)
            begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < 17; k++)
            begin
                send_curve(rand_curve());
            end
            wait_drained();
        end
        idle_on = 1'b1;

        repeat (100) @(negedge clk);
        $display("ran %0d curves and %0d segments over %0d register settings, %0d cycles",
                 curves_seen, segments_seen, 12, cycle_count);
        $display("covered scale and offset extremes, step counts 0, 1, 64, 127, stalls");
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
